[design/hdle_pkg.sv]
// Shared types, constants and character helpers for the hex dump line encoder.
`default_nettype none

package hdle_pkg;

    localparam int BYTES_PER_LINE = 16;
    localparam int ADDRESS_DIGITS = 8;
    localparam int FIFO_DEPTH     = 4;

    localparam int POS_W  = $clog2(BYTES_PER_LINE);
    localparam int CNT_W  = $clog2(BYTES_PER_LINE + 1);
    localparam int DIG_W  = (ADDRESS_DIGITS > 1) ? $clog2(ADDRESS_DIGITS) : 1;
    localparam int FPTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);

    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [DIG_W-1:0]  t_dig;
    typedef logic [FPTR_W-1:0] t_fptr;
    typedef logic [FCNT_W-1:0] t_fcnt;

    typedef enum logic {
        REQ_DATA = 1'b0,
        REQ_END  = 1'b1
    } t_req;

    typedef enum logic {
        CFG_GROUP_MASK = 1'b0,
        CFG_ISO_MODE   = 1'b1
    } t_cfg_idx;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_ZERO    = 8'h30;

    typedef struct packed {
        logic        is_end;
        logic        hdr;
        logic        close;
        t_pos        pos;
        logic [7:0]  data;
        logic [7:0]  txt;
        logic [31:0] addr;
    } t_cmd;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] v;
        v = 8'(nib);
        hex_char = (nib < 4'd10) ? (8'h30 + v) : (8'h57 + v);
    endfunction

    function automatic logic [7:0] printable(input logic [7:0] c, input logic iso);
        logic dot;
        dot = (c < 8'h20) ||
              (iso ? ((c >= 8'h7F) && (c < 8'hA0)) : (c >= 8'h7F));
        printable = dot ? CH_DOT : c;
    endfunction

    function automatic logic group_hit(input t_pos pos, input logic [2:0] gm);
        logic [7:0] p;
        logic [7:0] m;
        p = 8'(pos);
        m = 8'(gm);
        group_hit = ((p & m) == m);
    endfunction

endpackage

`default_nettype wire

[design/hdle_in_if.sv]
// Input channel: byte or end-of-stream beats.
`default_nettype none

interface hdle_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] data_byte;

    modport source (output valid, output req_type, output data_byte, input ready);
    modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

`default_nettype wire

[design/hdle_out_if.sv]
// Output channel: one dump character per beat.
`default_nettype none

interface hdle_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_of_run;

    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

`default_nettype wire

[design/hex_dump_line_encoder.sv]
// Top level: configuration registers, front end, command queue and character sequencer.
//
//   channel  | dir | beat contents
//   i_in     | in  | req_type, data_byte
//   o_out    | out | out_char, last_of_run (one character per beat)
//   i_cfg_*  | in  | register index, write data (group_mask, iso_mode)
//
// The sequencer emits one character per cycle while the output is not stalled:
// two hex digits per byte, plus a space on a group boundary; the address and
// separator open a line, text and newline close it; end beats pad, then close.
// The character sequencer sets the rate; the front end takes a beat per
// cycle while the four-entry command queue has room.
// Reset is synchronous, active low, and clears line position, address and queue.
// A stalled output holds its beat in the output register.
`default_nettype none

module hex_dump_line_encoder import hdle_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_idx,
    input  wire logic [2:0] i_cfg_data,
    hdle_in_if.sink         i_in,
    hdle_out_if.source      o_out
);

    logic [2:0] r_group_mask;
    logic       r_iso_mode;
    logic       fifo_full;
    logic       fifo_empty;
    logic       push;
    logic       pop;
    t_cmd       cmd_in;
    t_cmd       cmd_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_mask <= 3'd1;
            r_iso_mode   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_GROUP_MASK: r_group_mask <= i_cfg_data;
                CFG_ISO_MODE:   r_iso_mode   <= i_cfg_data[0];
                default:        r_iso_mode   <= r_iso_mode;
            endcase
        end
    end

    hdle_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_iso_mode  (r_iso_mode),
        .i_in        (i_in),
        .i_fifo_full (fifo_full),
        .o_push      (push),
        .o_cmd       (cmd_in)
    );

    hdle_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .i_pop   (pop),
        .o_full  (fifo_full),
        .o_empty (fifo_empty),
        .o_cmd   (cmd_out)
    );

    hdle_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_group_mask (r_group_mask),
        .i_fifo_empty (fifo_empty),
        .i_cmd        (cmd_out),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule

`default_nettype wire

[design/hdle_front.sv]
// Front end: accepts input beats, tracks line position and address, builds commands.
`default_nettype none

module hdle_front import hdle_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_iso_mode,
    hdle_in_if.sink   i_in,
    input  wire logic i_fifo_full,
    output logic      o_push,
    output t_cmd      o_cmd
);

    t_pos        r_pos;
    logic [31:0] r_addr;
    logic        accept;
    logic        is_end;
    logic        closing;

    assign i_in.ready = !i_fifo_full;
    assign accept     = i_in.valid && i_in.ready;
    assign is_end     = (t_req'(i_in.req_type) == REQ_END);
    assign closing    = (r_pos == t_pos'(BYTES_PER_LINE - 1));

    always_comb begin
        o_cmd.is_end = is_end;
        o_cmd.hdr    = (r_pos == '0);
        o_cmd.close  = is_end || closing;
        o_cmd.pos    = r_pos;
        o_cmd.data   = i_in.data_byte;
        o_cmd.txt    = printable(i_in.data_byte, i_iso_mode);
        o_cmd.addr   = r_addr;
        // drop an end beat on an empty line
        o_push       = accept && (!is_end || (r_pos != '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_addr <= '0;
        end else if (accept) begin
            if (is_end) begin
                r_pos  <= '0;
                r_addr <= '0;
            end else if (closing) begin
                r_pos  <= '0;
                r_addr <= r_addr + 32'(BYTES_PER_LINE);
            end else begin
                r_pos  <= r_pos + t_pos'(1);
            end
        end
    end

endmodule

`default_nettype wire

[design/hdle_fifo.sv]
// Command queue between front end and character sequencer.
`default_nettype none

module hdle_fifo import hdle_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_cmd      o_cmd
);

    t_cmd  r_mem [FIFO_DEPTH];
    t_fptr r_wr;
    t_fptr r_rd;
    t_fcnt r_cnt;
    logic  do_push;
    logic  do_pop;

    assign o_full  = (r_cnt == t_fcnt'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == t_fptr'(FIFO_DEPTH - 1)) ? '0 : r_wr + t_fptr'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == t_fptr'(FIFO_DEPTH - 1)) ? '0 : r_rd + t_fptr'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + t_fcnt'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - t_fcnt'(1);
            end
        end
    end

endmodule

`default_nettype wire

[design/hdle_back.sv]
// Back end: steps through each command and emits dump characters.
`default_nettype none

module hdle_back import hdle_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [2:0] i_group_mask,
    input  wire logic       i_fifo_empty,
    input  wire t_cmd       i_cmd,
    output logic            o_pop,
    hdle_out_if.source      o_out
);

    typedef enum logic [3:0] {
        PH_ADDR, PH_COLON, PH_SPACE, PH_HI, PH_LO, PH_GRP,
        PH_PAD1, PH_PAD2, PH_PADG, PH_CSP, PH_TXT, PH_NL
    } t_phase;

    logic       r_busy;
    t_phase     r_phase;
    t_cmd       r_cmd;
    t_dig       r_dig;
    t_cnt       r_idx;
    logic [7:0] r_text [BYTES_PER_LINE];
    logic       r_ov;
    logic [7:0] r_char;
    logic       r_last;

    logic       n_busy;
    t_phase     n_phase;
    t_dig       n_dig;
    t_cnt       n_idx;

    logic       step;
    logic       done;
    logic [7:0] cur_char;
    logic       cur_last;
    logic       hit_pos;
    logic       hit_idx;
    logic       pad_end;
    t_cnt       txt_n;
    logic [2:0] sel;

    assign o_out.valid       = r_ov;
    assign o_out.out_char    = r_char;
    assign o_out.last_of_run = r_last;

    assign step    = r_busy && (!r_ov || o_out.ready);
    assign hit_pos = group_hit(r_cmd.pos, i_group_mask);
    assign hit_idx = group_hit(r_idx[POS_W-1:0], i_group_mask);
    assign pad_end = (r_idx == t_cnt'(BYTES_PER_LINE - 1));
    assign txt_n   = r_cmd.is_end ? t_cnt'(r_cmd.pos) : t_cnt'(BYTES_PER_LINE);
    assign sel     = 3'(r_dig);
    assign done    = step && cur_last;
    assign o_pop   = !i_fifo_empty && (!r_busy || done);

    always_comb begin
        cur_char = CH_SPACE;
        cur_last = 1'b0;
        unique case (r_phase)
            PH_ADDR: begin
                cur_char = (32'(r_dig) >= 32'd8) ? CH_ZERO
                         : hex_char(4'(r_cmd.addr >> {sel, 2'b00}));
            end
            PH_COLON: cur_char = CH_COLON;
            PH_SPACE: cur_char = CH_SPACE;
            PH_HI:    cur_char = hex_char(r_cmd.data[7:4]);
            PH_LO: begin
                cur_char = hex_char(r_cmd.data[3:0]);
                cur_last = !hit_pos && !r_cmd.close;
            end
            PH_GRP: begin
                cur_char = CH_SPACE;
                cur_last = !r_cmd.close;
            end
            PH_PAD1, PH_PAD2, PH_PADG, PH_CSP: cur_char = CH_SPACE;
            PH_TXT:   cur_char = r_text[r_idx[POS_W-1:0]];
            PH_NL: begin
                cur_char = CH_NEWLINE;
                cur_last = 1'b1;
            end
            default:  cur_char = CH_SPACE;
        endcase
    end

    always_comb begin
        n_busy  = r_busy;
        n_phase = r_phase;
        n_dig   = r_dig;
        n_idx   = r_idx;
        if (step) begin
            unique case (r_phase)
                PH_ADDR: begin
                    if (r_dig == '0) begin
                        n_phase = PH_COLON;
                    end else begin
                        n_dig = r_dig - t_dig'(1);
                    end
                end
                PH_COLON: n_phase = PH_SPACE;
                PH_SPACE: n_phase = PH_HI;
                PH_HI:    n_phase = PH_LO;
                PH_LO: begin
                    if (hit_pos) begin
                        n_phase = PH_GRP;
                    end else if (r_cmd.close) begin
                        n_phase = PH_CSP;
                    end
                end
                PH_GRP: begin
                    if (r_cmd.close) begin
                        n_phase = PH_CSP;
                    end
                end
                PH_PAD1: n_phase = PH_PAD2;
                PH_PAD2, PH_PADG: begin
                    if ((r_phase == PH_PAD2) && hit_idx) begin
                        n_phase = PH_PADG;
                    end else if (pad_end) begin
                        n_phase = PH_CSP;
                    end else begin
                        n_phase = PH_PAD1;
                        n_idx   = r_idx + t_cnt'(1);
                    end
                end
                PH_CSP: begin
                    n_phase = PH_TXT;
                    n_idx   = '0;
                end
                PH_TXT: begin
                    if (r_idx == txt_n - t_cnt'(1)) begin
                        n_phase = PH_NL;
                    end else begin
                        n_idx = r_idx + t_cnt'(1);
                    end
                end
                PH_NL: n_phase = PH_NL;
                default: n_phase = PH_NL;
            endcase
            if (cur_last) begin
                n_busy = 1'b0;
            end
        end
        if (o_pop) begin
            n_busy = 1'b1;
            n_dig  = t_dig'(ADDRESS_DIGITS - 1);
            n_idx  = t_cnt'(i_cmd.pos);
            if (i_cmd.is_end) begin
                n_phase = PH_PAD1;
            end else if (i_cmd.hdr) begin
                n_phase = PH_ADDR;
            end else begin
                n_phase = PH_HI;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
            if (!i_cmd.is_end) begin
                r_text[i_cmd.pos] <= i_cmd.txt;
            end
        end
        if (step) begin
            r_char <= cur_char;
            r_last <= cur_last;
        end
        r_dig <= n_dig;
        r_idx <= n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= PH_NL;
            r_ov    <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_phase <= n_phase;
            if (step) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire
